[rtl/snfd_pkg.sv]
// ----------------------------------------------------------------------------
// snfd_pkg
// Shared codes and helpers for the SPI NOR flash device: bus event codes,
// command opcodes and the status byte layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snfd_pkg;

  // bus event codes carried by each input word
  localparam logic [1:0] EV_SEL_FALL = 2'd0;
  localparam logic [1:0] EV_BYTE     = 2'd1;
  localparam logic [1:0] EV_SEL_RISE = 2'd2;

  // command opcodes
  localparam logic [7:0] CMD_READ      = 8'h03;
  localparam logic [7:0] CMD_FAST_READ = 8'h0B;
  localparam logic [7:0] CMD_PROGRAM   = 8'h02;
  localparam logic [7:0] CMD_ERASE     = 8'h20;
  localparam logic [7:0] CMD_RDSR      = 8'h05;
  localparam logic [7:0] CMD_WRSR      = 8'h01;
  localparam logic [7:0] CMD_WREN      = 8'h06;
  localparam logic [7:0] CMD_WRDI      = 8'h04;

  // misc constants
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [7:0]  STATUS_MASK = 8'hFC;
  localparam logic [23:0] ADDR_ONE    = 24'd1;

  // frame phase codes
  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_ADDR3  = 3'd3;
  localparam logic [2:0] PH_DUMMY  = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  // commands that need the write-enable latch
  function automatic logic needs_latch(input logic [7:0] op);
    needs_latch = (op == CMD_PROGRAM) || (op == CMD_ERASE) || (op == CMD_WRSR);
  endfunction

  // commands followed by three address bytes
  function automatic logic has_address(input logic [7:0] op);
    has_address = (op == CMD_READ) || (op == CMD_FAST_READ) ||
                  (op == CMD_PROGRAM) || (op == CMD_ERASE);
  endfunction

endpackage

[rtl/snfd_in_if.sv]
// ----------------------------------------------------------------------------
// snfd_in_if
// Input channel: one bus event word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] mosi_byte;

  modport source (output valid, output operation, output mosi_byte, input ready);
  modport sink   (input valid, input operation, input mosi_byte, output ready);
endinterface

[rtl/snfd_out_if.sv]
// ----------------------------------------------------------------------------
// snfd_out_if
// Result channel: one returned byte and reject flag per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] miso_byte;
  logic       rejected;

  modport source (output valid, output miso_byte, output rejected, input ready);
  modport sink   (input valid, input miso_byte, input rejected, output ready);
endinterface

[rtl/spi_nor_flash_device_unit.sv]
// Result: a result word is registered in the execute state after its input word
// is taken, once the result register is free. A new input word is taken only after
// the previous one has been applied. A select rise that ends a sector erase walks
// the sector (one byte written per cycle through the single write port).
// Reset: synchronous active-low; afterwards the array is swept to FFh, and no
// input word is taken during the sweep.
// ----------------------------------------------------------------------------
// spi_nor_flash_device_unit
// SPI NOR flash device seen from its bus pins: read, fast read, page program,
// sector erase, status access and write-enable latch, array held in one RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_nor_flash_device_unit #(
  parameter int ADDR_BITS    = 16,
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  snfd_in_if.sink    in_ch,
  snfd_out_if.source out_ch
);
  import snfd_pkg::*;

  localparam int SECT_BITS  = $clog2(SECTOR_BYTES);
  localparam int ERASE_BITS = (SECT_BITS < ADDR_BITS) ? SECT_BITS : ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] SECT_MASK =
    ADDR_BITS'((64'(1) << ERASE_BITS) - 64'(1));
  localparam logic [23:0] PAGE_MASK = 24'(PAGE_BYTES - 1);
  localparam int DEPTH = 1 << ADDR_BITS;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_ERASE} state_t;

  // control and frame state
  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0]   base_r, base_nxt;
  logic [1:0]             ev_r, ev_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic [7:0]             opcode_r, opcode_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [23:0]            addr_r, addr_nxt;
  logic                   wel_r, wel_nxt;
  logic [7:0]             protect_r, protect_nxt;
  logic                   active_r, active_nxt;
  logic                   frame_rej_r, frame_rej_nxt;
  logic [7:0]             pending_r, pending_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_miso_r, out_miso_nxt;
  logic                   out_rej_r, out_rej_nxt;

  // array port signals
  logic [7:0]             mem [DEPTH];
  logic [7:0]             mem_rdata_r;
  logic                   mem_we, mem_re;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata;

  logic                   accept;
  logic                   slot_free;
  logic [ADDR_BITS-1:0]   addr_idx;
  logic [7:0]             status;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign accept           = in_ch.valid && (state_r == S_IDLE);
  assign slot_free        = !out_valid_r || out_ch.ready;
  assign addr_idx         = addr_r[ADDR_BITS-1:0];
  assign status           = (protect_r & STATUS_MASK) | {6'd0, wel_r, 1'b0};
  assign out_ch.valid     = out_valid_r;
  assign out_ch.miso_byte = out_miso_r;
  assign out_ch.rejected  = out_rej_r;

  // array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // next-state logic for the command engine
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    ev_nxt        = ev_r;
    byte_nxt      = byte_r;
    opcode_nxt    = opcode_r;
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    wel_nxt       = wel_r;
    protect_nxt   = protect_r;
    active_nxt    = active_r;
    frame_rej_nxt = frame_rej_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_miso_nxt  = out_miso_r;
    out_rej_nxt   = out_rej_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = IDLE_BYTE;
    mem_re        = 1'b0;
    mem_raddr     = addr_idx;

    case (state_r)
      // sweep the whole array to the erased value after reset
      S_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      // take a word and fetch the byte at the current address
      S_IDLE: begin
        if (accept) begin
          ev_nxt    = in_ch.operation;
          byte_nxt  = in_ch.mosi_byte;
          mem_re    = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      // apply the event once the result register is free
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_miso_nxt  = IDLE_BYTE;
          out_rej_nxt   = 1'b0;
          state_nxt     = S_IDLE;
          case (ev_r)
            EV_SEL_FALL: begin
              active_nxt    = 1'b1;
              phase_nxt     = PH_OPCODE;
              opcode_nxt    = 8'd0;
              frame_rej_nxt = 1'b0;
              addr_nxt      = 24'd0;
              pending_nxt   = 8'd0;
            end
            EV_BYTE: begin
              if (active_r) begin
                if (phase_r == PH_OPCODE) begin
                  opcode_nxt    = byte_r;
                  frame_rej_nxt = needs_latch(byte_r) && !wel_r;
                  phase_nxt     = PH_FIRST;
                end else if (has_address(opcode_r) && phase_r <= PH_ADDR3) begin
                  addr_nxt  = {addr_r[15:0], byte_r};
                  phase_nxt = phase_r + 3'd1;
                end else begin
                  case (opcode_r)
                    CMD_READ: begin
                      out_miso_nxt = mem_rdata_r;
                      addr_nxt     = addr_r + ADDR_ONE;
                    end
                    CMD_FAST_READ: begin
                      if (phase_r == PH_DUMMY) begin
                        phase_nxt = PH_DATA;
                      end else begin
                        out_miso_nxt = mem_rdata_r;
                        addr_nxt     = addr_r + ADDR_ONE;
                      end
                    end
                    CMD_PROGRAM: begin
                      // program clears bits only; address wraps inside the page
                      if (!frame_rej_r) begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_idx;
                        mem_wdata = mem_rdata_r & byte_r;
                        addr_nxt  = (addr_r & ~PAGE_MASK) |
                                    ((addr_r + ADDR_ONE) & PAGE_MASK);
                      end
                    end
                    CMD_RDSR: begin
                      out_miso_nxt = status;
                    end
                    CMD_WRSR: begin
                      if (phase_r == PH_FIRST) begin
                        pending_nxt = byte_r;
                        phase_nxt   = PH_SECOND;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
              end
            end
            EV_SEL_RISE: begin
              if (active_r) begin
                if (phase_r != PH_OPCODE) begin
                  if (frame_rej_r) begin
                    out_rej_nxt = 1'b1;
                  end else if (opcode_r == CMD_WREN) begin
                    wel_nxt = 1'b1;
                  end else if (opcode_r == CMD_WRDI) begin
                    wel_nxt = 1'b0;
                  end else if (opcode_r == CMD_ERASE && phase_r >= PH_DUMMY) begin
                    wel_nxt   = 1'b0;
                    base_nxt  = addr_idx & ~SECT_MASK;
                    cnt_nxt   = '0;
                    state_nxt = S_ERASE;
                  end else if (opcode_r == CMD_PROGRAM && phase_r >= PH_DUMMY) begin
                    wel_nxt = 1'b0;
                  end else if (opcode_r == CMD_WRSR && phase_r >= PH_SECOND) begin
                    protect_nxt = pending_r & STATUS_MASK;
                    wel_nxt     = 1'b0;
                  end
                end
                active_nxt    = 1'b0;
                phase_nxt     = PH_OPCODE;
                frame_rej_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // walk the sector writing the erased value
      S_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = base_r | (cnt_r & SECT_MASK);
        cnt_nxt   = cnt_r + 1'b1;
        if ((cnt_r & SECT_MASK) == SECT_MASK) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      opcode_r    <= 8'd0;
      phase_r     <= PH_OPCODE;
      addr_r      <= 24'd0;
      wel_r       <= 1'b0;
      protect_r   <= 8'd0;
      active_r    <= 1'b0;
      frame_rej_r <= 1'b0;
      pending_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      opcode_r    <= opcode_nxt;
      phase_r     <= phase_nxt;
      addr_r      <= addr_nxt;
      wel_r       <= wel_nxt;
      protect_r   <= protect_nxt;
      active_r    <= active_nxt;
      frame_rej_r <= frame_rej_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r     <= base_nxt;
    ev_r       <= ev_nxt;
    byte_r     <= byte_nxt;
    out_miso_r <= out_miso_nxt;
    out_rej_r  <= out_rej_nxt;
  end

`ifndef ASSERT_OFF
  // array read and write never share a cycle, so no forwarding is needed
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("array read and write in the same cycle");

  // a new result word only appears right after an execute cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result word raised outside execute");

  // a rejected frame never drives data
  a_reject_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (out_miso_r == IDLE_BYTE))
    else $error("reject flag with driven data");

  // frame phase stays within the data phase
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_DATA)
    else $error("frame phase out of range");
`endif

endmodule
